FILE: hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and functions of the 128-bit Feistel block cipher
// Holds the transaction payload types, the round-key type, the S-boxes,
// the round constants and the word permutations used by the datapath.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int ROUND_COUNT = 12;
    localparam int RC_SHIFT    = 14;

    // Function codes carried in the input transaction.
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic        func;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } rkey_t;

    // Round constants, round 0 in the lowest slot.
    localparam logic [ROUND_COUNT-1:0][6:0] RC_TABLE = {
        7'h22, 7'h51, 7'h25, 7'h5F, 7'h62, 7'h71,
        7'h35, 7'h57, 7'h66, 7'h73, 7'h34, 7'h5A
    };

    function automatic logic [3:0] fwd_sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h9;
            4'h2: y = 4'hD;
            4'h3: y = 4'h2;
            4'h4: y = 4'h5;
            4'h5: y = 4'hF;
            4'h6: y = 4'h3;
            4'h7: y = 4'h6;
            4'h8: y = 4'h7;
            4'h9: y = 4'hE;
            4'hA: y = 4'h0;
            4'hB: y = 4'h1;
            4'hC: y = 4'hA;
            4'hD: y = 4'h4;
            4'hE: y = 4'hB;
            default: y = 4'h8;
        endcase
        return y;
    endfunction

    function automatic logic [3:0] inv_sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hA;
            4'h1: y = 4'hB;
            4'h2: y = 4'h3;
            4'h3: y = 4'h6;
            4'h4: y = 4'hD;
            4'h5: y = 4'h4;
            4'h6: y = 4'h7;
            4'h7: y = 4'h8;
            4'h8: y = 4'hF;
            4'h9: y = 4'h1;
            4'hA: y = 4'hC;
            4'hB: y = 4'hE;
            4'hC: y = 4'h0;
            4'hD: y = 4'h2;
            4'hE: y = 4'h9;
            default: y = 4'h5;
        endcase
        return y;
    endfunction

    // Substitute all sixteen nibbles of a word, in place.
    function automatic logic [63:0] sub_fwd(input logic [63:0] x);
        logic [63:0] y;
        for (int n = 0; n < 16; n++) begin
            y[n*4 +: 4] = fwd_sbox(x[n*4 +: 4]);
        end
        return y;
    endfunction

    function automatic logic [63:0] sub_inv(input logic [63:0] x);
        logic [63:0] y;
        for (int n = 0; n < 16; n++) begin
            y[n*4 +: 4] = inv_sbox(x[n*4 +: 4]);
        end
        return y;
    endfunction

    // Swap the 16-bit words pairwise.
    function automatic logic [63:0] word_swap(input logic [63:0] x);
        return {x[47:32], x[63:48], x[15:0], x[31:16]};
    endfunction

    function automatic logic [63:0] rotl21(input logic [63:0] x);
        return {x[42:0], x[63:43]};
    endfunction

    function automatic logic [63:0] rotr21(input logic [63:0] x);
        return {x[20:0], x[63:21]};
    endfunction

    // Round constant placed in bits 20:14.
    function automatic logic [63:0] rc_word(input logic [6:0] rc);
        return {43'd0, rc, 14'd0};
    endfunction

    // One forward step of the key schedule.
    function automatic rkey_t key_step(input rkey_t k);
        rkey_t n;
        logic [63:0] w;
        w    = word_swap(k.lo);
        n.hi = w;
        n.lo = w ^ k.hi;
        return n;
    endfunction

endpackage

FILE: hw/rtl/fbc_key_sched.sv
// ----------------------------------------------------------------------------
// fbc_key_sched: round-key expansion
// Derives the twelve round keys from the held key. Each round key is a
// fixed XOR network of key bits, so the expansion is plain wiring and XOR.
// ----------------------------------------------------------------------------
module fbc_key_sched
    import fbc_pkg::*;
(
    input  logic [63:0]                   key_high,
    input  logic [63:0]                   key_low,
    output rkey_t [ROUND_COUNT-1:0]       round_keys
);

    rkey_t [ROUND_COUNT:0] chain;

    // The key itself starts the schedule; round r uses the key after r+1 steps.
    assign chain[0].hi = key_high;
    assign chain[0].lo = key_low;

    for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_step
        assign chain[i+1]    = key_step(chain[i]);
        assign round_keys[i] = chain[i+1];
    end

endmodule

FILE: hw/rtl/fbc_rounds.sv
// ----------------------------------------------------------------------------
// fbc_rounds: twelve cipher rounds, both directions
// Combinational round network between the input and result registers.
// Both directions share the round keys; the function bit picks the result.
// ----------------------------------------------------------------------------
module fbc_rounds
    import fbc_pkg::*;
(
    input  in_t                           blk,
    input  rkey_t [ROUND_COUNT-1:0]       round_keys,
    output out_t                          res
);

    logic [ROUND_COUNT:0][63:0] enc_h;
    logic [ROUND_COUNT:0][63:0] enc_l;
    logic [ROUND_COUNT:0][63:0] dec_h;
    logic [ROUND_COUNT:0][63:0] dec_l;

    assign enc_h[0] = blk.data_high;
    assign enc_l[0] = blk.data_low;
    assign dec_h[0] = blk.data_high;
    assign dec_l[0] = blk.data_low;

    for (genvar j = 0; j < ROUND_COUNT; j++) begin : g_round
        logic [63:0] enc_s;
        logic [63:0] enc_t;
        logic [63:0] dec_t;

        // Encipher round j.
        assign enc_s      = sub_fwd(enc_h[j] ^ round_keys[j].hi);
        assign enc_t      = rotl21(word_swap(enc_l[j] ^ rc_word(RC_TABLE[j])
                                             ^ round_keys[j].lo));
        assign enc_h[j+1] = enc_s ^ enc_t;
        assign enc_l[j+1] = enc_s;

        // Decipher runs the rounds from the last one back to the first.
        assign dec_t      = word_swap(rotr21(dec_h[j] ^ dec_l[j]))
                            ^ round_keys[ROUND_COUNT-1-j].lo;
        assign dec_l[j+1] = dec_t ^ rc_word(RC_TABLE[ROUND_COUNT-1-j]);
        assign dec_h[j+1] = sub_inv(dec_l[j]) ^ round_keys[ROUND_COUNT-1-j].hi;
    end

    // Select the direction asked for by the transaction.
    always_comb
    begin
        case (blk.func)
            FUNC_DECRYPT:
            begin
                res.result_high = dec_h[ROUND_COUNT];
                res.result_low  = dec_l[ROUND_COUNT];
            end
            default:
            begin
                res.result_high = enc_h[ROUND_COUNT];
                res.result_low  = enc_l[ROUND_COUNT];
            end
        endcase
    end

endmodule

FILE: hw/rtl/feistel_block_cipher_128_core.sv
// ----------------------------------------------------------------------------
// feistel_block_cipher_128_core: 128-bit, twelve-round Feistel block cipher
// Flow: a block is taken into the input register, crosses the round network
// and is captured in the result register; a stalled, full result register
// holds it in the input register. Throughput: one block per cycle when the
// result channel does not stall; the twelve rounds are one combinational
// pass between the two registers. Reset clears both valid flags and the key.
// ----------------------------------------------------------------------------
module feistel_block_cipher_128_core
    import fbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_reg_t    cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]             key_high_reg;
    logic [63:0]             key_low_reg;
    logic                    stage_valid_reg;
    logic                    stage_valid_next;
    in_t                     stage_data_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    out_t                    out_data_reg;
    rkey_t [ROUND_COUNT-1:0] round_keys;
    out_t                    round_res;
    logic                    out_free;
    logic                    stage_move;
    logic                    in_take;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Pipeline flow: the result register frees up when empty or taken.
    assign out_free   = !out_valid_reg || !out_stall;
    assign stage_move = stage_valid_reg && out_free;
    assign in_stall   = stage_valid_reg && !out_free;
    assign in_take    = in_valid && !in_stall;

    assign stage_valid_next = in_take || (stage_valid_reg && !stage_move);
    assign out_valid_next   = stage_move || (out_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_data_reg <= in_data;
        end
        if (stage_move)
        begin
            out_data_reg <= round_res;
        end
    end

    fbc_key_sched u_key_sched (
        .key_high   (key_high_reg),
        .key_low    (key_low_reg),
        .round_keys (round_keys)
    );

    fbc_rounds u_rounds (
        .blk        (stage_data_reg),
        .round_keys (round_keys),
        .res        (round_res)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
